FILE: sv/bta_pkg.sv
// Shared widths, codes and handshake structs of the block table allocator.
`timescale 1ns / 1ps

package bta_pkg;

  // Field widths of the request and response channels
  localparam int OP_W    = 2;
  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 16;
  localparam int STAT_W  = 2;
  localparam int BOFF_W  = 14;
  localparam int RUN_W   = 9;
  localparam int PCT_W   = 7;

  // Table entry holds a run length, 0 = free
  localparam int ENTRY_W = 9;

  // Constant divider: dividend covers size + block - 1 and used * 100
  localparam int DIV_W   = 19;

  localparam int PCT_SCALE = 100;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_USAGE = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Divider command and result; by_table picks the table size as divisor
  typedef struct packed {
    logic             start;
    logic             by_table;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/bta_req_if.sv
// Request channel of the block table allocator.
`timescale 1ns / 1ps

interface bta_req_if;
  logic                        valid;
  logic                        ready;
  logic [bta_pkg::OP_W-1:0]    op;
  logic [bta_pkg::SIZE_W-1:0]  size_bytes;
  logic [bta_pkg::OFF_W-1:0]   offset_bytes;

  modport source (output valid, output op, output size_bytes, output offset_bytes,
                  input ready);
  modport sink   (input valid, input op, input size_bytes, input offset_bytes,
                  output ready);
endinterface

FILE: sv/bta_rsp_if.sv
// Response channel of the block table allocator.
`timescale 1ns / 1ps

interface bta_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bta_pkg::STAT_W-1:0]  status;
  logic [bta_pkg::BOFF_W-1:0]  block_offset;
  logic [bta_pkg::RUN_W-1:0]   run_blocks;
  logic [bta_pkg::PCT_W-1:0]   usage_percent;

  modport source (output valid, output status, output block_offset, output run_blocks,
                  output usage_percent, input ready);
  modport sink   (input valid, input status, input block_offset, input run_blocks,
                  input usage_percent, output ready);
endinterface

FILE: sv/bta_div.sv
// Divider by the block size or the table size through a reciprocal multiply, with a registered quotient.
`timescale 1ns / 1ps

module bta_div #(
  parameter int BLOCK_BYTES   = 64,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  bta_pkg::div_req_t   req,
  output bta_pkg::div_rsp_t   rsp
);
  import bta_pkg::*;

  // floor(x / d) == (x * ceil(2^s / d)) >> s for x < 2^DIV_W, s = DIV_W + clog2(d)
  localparam int RCP_W  = DIV_W + 1;
  localparam int PROD_W = DIV_W + RCP_W;
  localparam int BLK_SH = DIV_W + $clog2(BLOCK_BYTES);
  localparam int TBL_SH = DIV_W + $clog2(TABLE_ENTRIES);
  localparam longint BLK_RCP =
    ((longint'(1) << BLK_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);
  localparam longint TBL_RCP =
    ((longint'(1) << TBL_SH) + longint'(TABLE_ENTRIES) - 1) / longint'(TABLE_ENTRIES);

  logic [DIV_W-1:0]  quo;
  logic              done;
  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod;

  // Shared multiplier, reciprocal picked by the divisor select
  assign rcp  = req.by_table ? RCP_W'(TBL_RCP) : RCP_W'(BLK_RCP);
  assign prod = PROD_W'(req.dividend) * PROD_W'(rcp);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.by_table) begin
        quo <= DIV_W'(prod >> TBL_SH);
      end else begin
        quo <= DIV_W'(prod >> BLK_SH);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: sv/bta_mem.sv
// Allocation table storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module bta_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [bta_pkg::ENTRY_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [bta_pkg::ENTRY_W-1:0]  rdata
);
  import bta_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/block_table_allocator.sv
// Block table allocator: first-fit-from-top run allocation over a block table.
// Steps: allocate divides by the block size, scans down for a free run and marks it; free
//   divides by the block size, reads the stored run length and clears it; usage counts used
//   entries and divides by the table size. The table walk dominates.
// Throughput: one request at a time; ready returns as the result enters the output register,
//   so the next request is taken only then, and waits while the output register is held.
// Reset: synchronous; a clearing pass writes every entry to free,
//   with no request taken until it ends.
`timescale 1ns / 1ps

module block_table_allocator #(
  parameter int TABLE_ENTRIES = 256,
  parameter int BLOCK_BYTES   = 64
) (
  input  logic       clk,
  input  logic       rst,
  bta_req_if.sink    req,
  bta_rsp_if.source  rsp
);
  import bta_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned POOL_BYTES = TABLE_ENTRIES * BLOCK_BYTES;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [10:0] {
    S_INIT      = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_DIVGO     = 11'b000_0000_0100,
    S_DIVWAIT   = 11'b000_0000_1000,
    S_ALOC_SCAN = 11'b000_0001_0000,
    S_MARK      = 11'b000_0010_0000,
    S_FREE_RD   = 11'b000_0100_0000,
    S_FREE_LEN  = 11'b000_1000_0000,
    S_CLEAR     = 11'b001_0000_0000,
    S_USE_SCAN  = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op_q;

  // Walk pointer and read pipeline
  logic [AW-1:0]       iss_idx;
  logic                iss_live;
  logic                rd_v;
  logic [AW-1:0]       rd_idx;

  // Allocate
  logic [CNT_W-1:0]    need;
  logic [CNT_W-1:0]    found;
  logic [CNT_W-1:0]    found_n;
  logic [AW-1:0]       mark_ptr;
  logic [CNT_W-1:0]    mark_left;

  // Free
  logic [AW-1:0]       free_idx;
  logic [ENTRY_W-1:0]  clr_len;
  logic [ENTRY_W-1:0]  clr_k;
  logic [AW:0]         clr_ptr;
  logic                clr_end;

  // Usage
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    used_n;
  logic                use_mul;

  // Divider
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [DIV_W-1:0]    div_dividend;
  logic                div_by_table;

  // Table port
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  // Result being built, and the output register
  status_t             res_status;
  logic [BOFF_W-1:0]   res_boff;
  logic [RUN_W-1:0]    res_run;
  logic [PCT_W-1:0]    res_pct;
  logic                out_valid;
  status_t             out_status;
  logic [BOFF_W-1:0]   out_boff;
  logic [RUN_W-1:0]    out_run;
  logic [PCT_W-1:0]    out_pct;

  logic                req_xfer;
  logic                out_free;

  assign req_xfer = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  assign found_n = (mem_rdata == '0) ? found + 1'b1 : '0;
  assign used_n  = used + CNT_W'(mem_rdata != '0);
  assign clr_end = (clr_k == clr_len) || (clr_ptr == (AW + 1)'(TABLE_ENTRIES));

  // Table write and read port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = iss_idx;
    mem_wdata = '0;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = mark_ptr;
        mem_wdata = ENTRY_W'(need);
      end
      S_CLEAR: begin
        mem_we    = !clr_end;
        mem_waddr = clr_ptr[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_raddr = (state == S_FREE_RD) ? free_idx : iss_idx;

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.by_table = div_by_table;
  assign div_req.dividend = div_dividend;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      iss_idx   <= '0;
      iss_live  <= 1'b0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
      use_mul   <= 1'b0;
    end else begin
      rd_v   <= iss_live && ((state == S_ALOC_SCAN) || (state == S_USE_SCAN));
      rd_idx <= iss_idx;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        // Clearing pass after reset
        S_INIT: begin
          if (iss_idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            iss_idx <= iss_idx + 1'b1;
          end
        end

        S_IDLE: begin
          if (req_xfer) begin
            op_q       <= req.op;
            res_status <= ST_OK;
            res_boff   <= '0;
            res_run    <= '0;
            res_pct    <= '0;
            use_mul    <= 1'b0;
            case (req.op)
              OP_ALLOC: begin
                if (req.size_bytes == '0) begin
                  res_status <= ST_ZERO;
                  state      <= S_DONE;
                end else begin
                  div_dividend <= DIV_W'(req.size_bytes) + DIV_W'(BLOCK_BYTES - 1);
                  div_by_table <= 1'b0;
                  state        <= S_DIVGO;
                end
              end
              OP_FREE: begin
                if (32'(req.offset_bytes) >= POOL_BYTES) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  div_dividend <= DIV_W'(req.offset_bytes);
                  div_by_table <= 1'b0;
                  state        <= S_DIVGO;
                end
              end
              OP_USAGE: begin
                iss_idx  <= '0;
                iss_live <= 1'b1;
                used     <= '0;
                state    <= S_USE_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_DIVGO: begin
          state <= S_DIVWAIT;
        end

        // Quotient is block count, block index or percentage
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            case (op_q)
              OP_ALLOC: begin
                if (32'(div_rsp.quotient) > 32'(TABLE_ENTRIES)) begin
                  res_status <= ST_NOSPACE;
                  state      <= S_DONE;
                end else begin
                  need     <= CNT_W'(div_rsp.quotient);
                  found    <= '0;
                  iss_idx  <= LAST_IDX;
                  iss_live <= 1'b1;
                  state    <= S_ALOC_SCAN;
                end
              end
              OP_FREE: begin
                free_idx <= AW'(div_rsp.quotient);
                state    <= S_FREE_RD;
              end
              default: begin
                res_pct <= PCT_W'(div_rsp.quotient);
                state   <= S_DONE;
              end
            endcase
          end
        end

        // Downward scan for a free run of the needed length
        S_ALOC_SCAN: begin
          if (iss_live) begin
            if (iss_idx == '0) begin
              iss_live <= 1'b0;
            end else begin
              iss_idx <= iss_idx - 1'b1;
            end
          end
          if (rd_v) begin
            found <= found_n;
            if (found_n == need) begin
              iss_live  <= 1'b0;
              mark_ptr  <= rd_idx;
              mark_left <= need;
              res_boff  <= BOFF_W'(32'(rd_idx) * 32'(BLOCK_BYTES));
              res_run   <= RUN_W'(need);
              state     <= S_MARK;
            end else if (rd_idx == '0) begin
              res_status <= ST_NOSPACE;
              state      <= S_DONE;
            end
          end
        end

        // Write the run length into every entry of the run
        S_MARK: begin
          mark_ptr  <= mark_ptr + 1'b1;
          mark_left <= mark_left - 1'b1;
          if (mark_left == CNT_W'(1)) begin
            state <= S_DONE;
          end
        end

        S_FREE_RD: begin
          state <= S_FREE_LEN;
        end

        S_FREE_LEN: begin
          clr_len <= mem_rdata;
          clr_k   <= '0;
          clr_ptr <= {1'b0, free_idx};
          state   <= S_CLEAR;
        end

        // Clear as many entries as the stored length, stopping at the table end
        S_CLEAR: begin
          if (clr_end) begin
            res_run <= RUN_W'(clr_k);
            state   <= S_DONE;
          end else begin
            clr_k   <= clr_k + 1'b1;
            clr_ptr <= clr_ptr + 1'b1;
          end
        end

        // Count used entries, then scale and divide by the table size
        S_USE_SCAN: begin
          if (use_mul) begin
            div_dividend <= DIV_W'(used) * DIV_W'(PCT_SCALE);
            div_by_table <= 1'b1;
            state        <= S_DIVGO;
          end else begin
            if (iss_live) begin
              if (iss_idx == LAST_IDX) begin
                iss_live <= 1'b0;
              end else begin
                iss_idx <= iss_idx + 1'b1;
              end
            end
            if (rd_v) begin
              used <= used_n;
              if (rd_idx == LAST_IDX) begin
                use_mul <= 1'b1;
              end
            end
          end
        end

        // Hand the result to the output register once it is free
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_boff   <= res_boff;
            out_run    <= res_run;
            out_pct    <= res_pct;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bta_div #(
    .BLOCK_BYTES   (BLOCK_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bta_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.block_offset   = out_boff;
  assign rsp.run_blocks     = out_run;
  assign rsp.usage_percent  = out_pct;

  // Divider finishes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIVWAIT)
    else $error("divider finished outside its wait state");

  // Table is written only by the clearing, marking and freeing steps
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INIT || state == S_MARK || state == S_CLEAR))
    else $error("table write outside a write step");

  // A finished result waits while the output register is still occupied
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !rsp.ready) |=> state == S_DONE)
    else $error("result left done state over an occupied output");

  // No request is taken while the previous one is still being worked
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state != S_IDLE)
    else $error("sequencer stayed idle after taking a request");

endmodule
